/* hdl/ovn_pkg.sv */
// Shared types and constants for the octave value noise block.
package ovn_pkg;

  localparam int COORD_W    = 6;
  localparam int SEED_W     = 16;
  localparam int NOISE_W    = 16;
  localparam int OCT_W      = 3;
  localparam int BIAS_W     = 16;
  localparam int SCALE_W    = 40;
  localparam int WSUM_W     = 43;
  localparam int ACC_W      = 60;
  localparam int REM_W      = WSUM_W + 1;
  localparam int DIV_CNT_W  = 4;
  localparam int IN_TDATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [16:0]        WEIGHT_ONE = 17'h10000;
  localparam logic [SCALE_W-1:0] SCALE_ONE  = 40'h00_0001_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_BIAS = 2'd1;

  localparam logic [OCT_W-1:0]  OCTAVE_COUNT_RST = 3'd5;
  localparam logic [BIAS_W-1:0] INVERSE_BIAS_RST = 16'd2048;

  localparam logic [1:0] CORNER_X1Y1 = 2'b00;
  localparam logic [1:0] CORNER_X2Y1 = 2'b01;
  localparam logic [1:0] CORNER_X1Y2 = 2'b10;
  localparam logic [1:0] CORNER_X2Y2 = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD00,
    ST_RD10,
    ST_RD01,
    ST_RD11,
    ST_BOT1,
    ST_COL1,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRITE,
    OP_LOAD,
    OP_TOP0,
    OP_TOP1,
    OP_BOT0,
    OP_BOT1_COL0,
    OP_COL1,
    OP_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] corner;
  } ovn_cmd_t;

  typedef struct packed {
    logic last_oct;
    logic div_last;
  } ovn_sts_t;

endpackage

/* hdl/octave_value_noise_2d.sv */
// Top level: octave value noise over a square seed map, with configuration registers.
// A seed write leaves the controller idle; the next item can transfer in the following cycle.
// A query runs four seed reads, blend and weighting for each octave in use, then a restoring division
// and an output step, held while an earlier result waits; in_tready stays low until the query has
// handed its result to the output register, so a new item is not taken while a query runs.
// Synchronous active-low reset restores octave_count 5 and inverse_bias 2048; seeds stay.
module octave_value_noise_2d #(
  parameter int MAP_SIDE_LOG2 = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tdata: cell_x[5:0], cell_y[11:6], seed_value[27:12], zero fill[31:28]
  input  logic [ovn_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: operation
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: noise[15:0]
  output logic [ovn_pkg::NOISE_W-1:0]        out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ovn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ovn_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int MaxOct = (MAP_SIDE_LOG2 + 1 < 7) ? MAP_SIDE_LOG2 + 1 : 7;

  logic [ovn_pkg::OCT_W-1:0]  oct_cnt_r, oct_cnt_nxt, oct_total;
  logic [ovn_pkg::BIAS_W-1:0] inv_bias_r, inv_bias_nxt;
  ovn_pkg::ovn_cmd_t cmd;
  ovn_pkg::ovn_sts_t sts;

  assign cfg_ready = 1'b1;

  always_comb begin
    oct_cnt_nxt  = oct_cnt_r;
    inv_bias_nxt = inv_bias_r;
    if (cfg_valid) begin
      case (cfg_index)
        ovn_pkg::CFG_OCTAVE_COUNT: oct_cnt_nxt  = cfg_data[ovn_pkg::OCT_W-1:0];
        ovn_pkg::CFG_INVERSE_BIAS: inv_bias_nxt = cfg_data[ovn_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r  <= ovn_pkg::OCTAVE_COUNT_RST;
      inv_bias_r <= ovn_pkg::INVERSE_BIAS_RST;
    end else begin
      oct_cnt_r  <= oct_cnt_nxt;
      inv_bias_r <= inv_bias_nxt;
    end
  end

  always_comb begin
    if (oct_cnt_r == '0) begin
      oct_total = ovn_pkg::OCT_W'(1);
    end else if (oct_cnt_r > ovn_pkg::OCT_W'(MaxOct)) begin
      oct_total = ovn_pkg::OCT_W'(MaxOct);
    end else begin
      oct_total = oct_cnt_r;
    end
  end

  ovn_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_operation (in_tuser),
    .in_tready    (in_tready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .sts          (sts),
    .cmd          (cmd)
  );

  ovn_datapath #(
    .MAP_SIDE_LOG2 (MAP_SIDE_LOG2)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cell_x       (in_tdata[5:0]),
    .cell_y       (in_tdata[11:6]),
    .seed_value   (in_tdata[27:12]),
    .oct_total    (oct_total),
    .inverse_bias (inv_bias_r),
    .noise        (out_tdata)
  );

endmodule

/* hdl/ovn_datapath.sv */
// Datapath: seed memory, bilinear blend, octave weighting and restoring divider.
module ovn_datapath #(
  parameter int MAP_SIDE_LOG2 = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ovn_pkg::ovn_cmd_t              cmd,
  output ovn_pkg::ovn_sts_t              sts,
  input  logic [ovn_pkg::COORD_W-1:0]    cell_x,
  input  logic [ovn_pkg::COORD_W-1:0]    cell_y,
  input  logic [ovn_pkg::SEED_W-1:0]     seed_value,
  input  logic [ovn_pkg::OCT_W-1:0]      oct_total,
  input  logic [ovn_pkg::BIAS_W-1:0]     inverse_bias,
  output logic [ovn_pkg::NOISE_W-1:0]    noise
);

  localparam int L     = MAP_SIDE_LOG2;
  localparam int AW    = 2 * L;
  localparam int DEPTH = 1 << AW;

  logic [ovn_pkg::SEED_W-1:0] seed_mem [DEPTH];

  logic [L+ovn_pkg::COORD_W-1:0] x_ext, y_ext;
  logic [L-1:0]  x_in, y_in;
  logic [L-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic [ovn_pkg::OCT_W-1:0] oct_r, oct_nxt, n_r, n_nxt;
  logic [L-1:0]  pm, pitch, x1, y1, x2, y2, fx, fy, xs, ys;
  logic [L+15:0] fx_ext, fy_ext;
  logic [15:0]   bx_base, by_base, bx, by;
  logic [16:0]   wx0, wy0, rw, cw;
  logic [AW-1:0] raddr, waddr;
  logic [ovn_pkg::SEED_W-1:0] rdata_r;

  logic [32:0] row_prod;
  logic [31:0] cin;
  logic [48:0] col_prod;
  logic [31:0] top_r, top_nxt, bot_r, bot_nxt;
  logic [47:0] v_r, v_nxt, v_rnd;
  logic [15:0] sample;

  logic [ovn_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [55:0] wprod, sprod;
  logic [56:0] srnd;
  logic [44:0] sshift;
  logic [ovn_pkg::ACC_W-1:0]  acc_r, acc_nxt, num;
  logic [ovn_pkg::WSUM_W-1:0] wsum_r, wsum_nxt;

  logic [ovn_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [ovn_pkg::REM_W:0]       trial, dvs;
  logic                          ge;
  logic [15:0]                   nlo_r, nlo_nxt;
  logic [ovn_pkg::NOISE_W-1:0]   q_r, q_nxt, noise_r, noise_nxt;
  logic [ovn_pkg::DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;

  assign x_ext = {{L{1'b0}}, cell_x};
  assign y_ext = {{L{1'b0}}, cell_y};
  assign x_in  = x_ext[L-1:0];
  assign y_in  = y_ext[L-1:0];

  // grid corners and blend fractions of the current octave
  assign pm      = {L{1'b1}} >> oct_r;
  assign pitch   = pm + L'(1);
  assign x1      = x_r & ~pm;
  assign y1      = y_r & ~pm;
  assign x2      = x1 + pitch;
  assign y2      = y1 + pitch;
  assign fx      = x_r & pm;
  assign fy      = y_r & pm;
  assign fx_ext  = {fx, 16'h0000};
  assign fy_ext  = {fy, 16'h0000};
  assign bx_base = 16'(fx_ext >> L);
  assign by_base = 16'(fy_ext >> L);
  assign bx      = bx_base << oct_r;
  assign by      = by_base << oct_r;
  assign wx0     = ovn_pkg::WEIGHT_ONE - {1'b0, bx};
  assign wy0     = ovn_pkg::WEIGHT_ONE - {1'b0, by};

  assign xs    = cmd.corner[0] ? x2 : x1;
  assign ys    = cmd.corner[1] ? y2 : y1;
  assign raddr = {ys, xs};
  assign waddr = {y_in, x_in};

  always_ff @(posedge clk) begin
    if (cmd.op == ovn_pkg::OP_WRITE) begin
      seed_mem[waddr] <= seed_value;
    end
    rdata_r <= seed_mem[raddr];
  end

  assign rw = (cmd.op == ovn_pkg::OP_TOP0 || cmd.op == ovn_pkg::OP_BOT0) ? wx0 : {1'b0, bx};
  assign row_prod = 33'(rw) * 33'(rdata_r);
  assign cw  = (cmd.op == ovn_pkg::OP_COL1) ? {1'b0, by} : wy0;
  assign cin = (cmd.op == ovn_pkg::OP_COL1) ? bot_r : top_r;
  assign col_prod = 49'(cw) * 49'(cin);

  assign v_rnd  = v_r + 48'h0000_8000_0000;
  assign sample = v_rnd[47:32];

  assign wprod  = 56'(sample) * 56'(scale_r);
  assign sprod  = 56'(scale_r) * 56'(inverse_bias);
  assign srnd   = {1'b0, sprod} + 57'd2048;
  assign sshift = srnd[56:12];

  assign num   = acc_r + ovn_pkg::ACC_W'(wsum_r >> 1);
  assign trial = {rem_r, nlo_r[15]};
  assign dvs   = {2'b00, wsum_r};
  assign ge    = trial >= dvs;

  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    oct_nxt   = oct_r;
    n_nxt     = n_r;
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    v_nxt     = v_r;
    acc_nxt   = acc_r;
    wsum_nxt  = wsum_r;
    scale_nxt = scale_r;
    rem_nxt   = rem_r;
    nlo_nxt   = nlo_r;
    q_nxt     = q_r;
    dcnt_nxt  = dcnt_r;
    noise_nxt = noise_r;
    case (cmd.op)
      ovn_pkg::OP_LOAD: begin
        x_nxt     = x_in;
        y_nxt     = y_in;
        oct_nxt   = '0;
        n_nxt     = oct_total;
        acc_nxt   = '0;
        wsum_nxt  = '0;
        scale_nxt = ovn_pkg::SCALE_ONE;
      end
      ovn_pkg::OP_TOP0: top_nxt = row_prod[31:0];
      ovn_pkg::OP_TOP1: top_nxt = top_r + row_prod[31:0];
      ovn_pkg::OP_BOT0: bot_nxt = row_prod[31:0];
      ovn_pkg::OP_BOT1_COL0: begin
        bot_nxt = bot_r + row_prod[31:0];
        v_nxt   = col_prod[47:0];
      end
      ovn_pkg::OP_COL1: v_nxt = v_r + col_prod[47:0];
      ovn_pkg::OP_ACC: begin
        acc_nxt   = acc_r + ovn_pkg::ACC_W'(wprod);
        wsum_nxt  = wsum_r + ovn_pkg::WSUM_W'(scale_r);
        scale_nxt = (|sshift[44:40]) ? '1 : sshift[39:0];
        oct_nxt   = oct_r + ovn_pkg::OCT_W'(1);
      end
      ovn_pkg::OP_DIV_INIT: begin
        rem_nxt  = num[ovn_pkg::ACC_W-1:16];
        nlo_nxt  = num[15:0];
        dcnt_nxt = '0;
      end
      ovn_pkg::OP_DIV_STEP: begin
        rem_nxt  = ge ? ovn_pkg::REM_W'(trial - dvs) : trial[ovn_pkg::REM_W-1:0];
        nlo_nxt  = {nlo_r[14:0], 1'b0};
        q_nxt    = {q_r[14:0], ge};
        dcnt_nxt = dcnt_r + ovn_pkg::DIV_CNT_W'(1);
      end
      ovn_pkg::OP_OUT: noise_nxt = q_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r  <= '0;
      n_r    <= ovn_pkg::OCT_W'(1);
      dcnt_r <= '0;
    end else begin
      oct_r  <= oct_nxt;
      n_r    <= n_nxt;
      dcnt_r <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    top_r   <= top_nxt;
    bot_r   <= bot_nxt;
    v_r     <= v_nxt;
    acc_r   <= acc_nxt;
    wsum_r  <= wsum_nxt;
    scale_r <= scale_nxt;
    rem_r   <= rem_nxt;
    nlo_r   <= nlo_nxt;
    q_r     <= q_nxt;
    noise_r <= noise_nxt;
  end

  assign sts.last_oct = (ovn_pkg::OCT_W'(oct_r + ovn_pkg::OCT_W'(1)) == n_r);
  assign sts.div_last = (dcnt_r == '1);
  assign noise        = noise_r;

  a_wsum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ovn_pkg::OP_DIV_INIT |-> wsum_r >= ovn_pkg::WSUM_W'(ovn_pkg::SCALE_ONE))
    else $error("weight sum below one at division start");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ovn_pkg::OP_DIV_STEP |-> {1'b0, wsum_r} > rem_r)
    else $error("partial remainder not below divisor");

  a_oct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ovn_pkg::OP_ACC |-> oct_r < n_r)
    else $error("octave index past octave count");

endmodule

/* hdl/ovn_ctrl.sv */
// Controller: sequences memory reads, octave accumulation, division and result hand-off.
module ovn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_operation,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  ovn_pkg::ovn_sts_t sts,
  output ovn_pkg::ovn_cmd_t cmd
);

  ovn_pkg::ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ovn_pkg::ST_IDLE: begin
        if (in_tvalid && in_operation) begin
          state_nxt = ovn_pkg::ST_RD00;
        end
      end
      ovn_pkg::ST_RD00:     state_nxt = ovn_pkg::ST_RD10;
      ovn_pkg::ST_RD10:     state_nxt = ovn_pkg::ST_RD01;
      ovn_pkg::ST_RD01:     state_nxt = ovn_pkg::ST_RD11;
      ovn_pkg::ST_RD11:     state_nxt = ovn_pkg::ST_BOT1;
      ovn_pkg::ST_BOT1:     state_nxt = ovn_pkg::ST_COL1;
      ovn_pkg::ST_COL1:     state_nxt = ovn_pkg::ST_ACC;
      ovn_pkg::ST_ACC: begin
        state_nxt = sts.last_oct ? ovn_pkg::ST_DIV_INIT : ovn_pkg::ST_RD00;
      end
      ovn_pkg::ST_DIV_INIT: state_nxt = ovn_pkg::ST_DIV_STEP;
      ovn_pkg::ST_DIV_STEP: begin
        if (sts.div_last) begin
          state_nxt = ovn_pkg::ST_DONE;
        end
      end
      ovn_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ovn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ovn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.op     = ovn_pkg::OP_NOP;
    cmd.corner = ovn_pkg::CORNER_X1Y1;
    case (state_r)
      ovn_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = in_operation ? ovn_pkg::OP_LOAD : ovn_pkg::OP_WRITE;
        end
      end
      ovn_pkg::ST_RD00: cmd.corner = ovn_pkg::CORNER_X1Y1;
      ovn_pkg::ST_RD10: begin
        cmd.corner = ovn_pkg::CORNER_X2Y1;
        cmd.op     = ovn_pkg::OP_TOP0;
      end
      ovn_pkg::ST_RD01: begin
        cmd.corner = ovn_pkg::CORNER_X1Y2;
        cmd.op     = ovn_pkg::OP_TOP1;
      end
      ovn_pkg::ST_RD11: begin
        cmd.corner = ovn_pkg::CORNER_X2Y2;
        cmd.op     = ovn_pkg::OP_BOT0;
      end
      ovn_pkg::ST_BOT1:     cmd.op = ovn_pkg::OP_BOT1_COL0;
      ovn_pkg::ST_COL1:     cmd.op = ovn_pkg::OP_COL1;
      ovn_pkg::ST_ACC:      cmd.op = ovn_pkg::OP_ACC;
      ovn_pkg::ST_DIV_INIT: cmd.op = ovn_pkg::OP_DIV_INIT;
      ovn_pkg::ST_DIV_STEP: cmd.op = ovn_pkg::OP_DIV_STEP;
      ovn_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.op = ovn_pkg::OP_OUT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.op == ovn_pkg::OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ovn_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ovn_pkg::ST_DONE && out_free |=> out_valid_r)
    else $error("finished result not presented");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ovn_pkg::ST_IDLE && in_tvalid && !in_operation |=> state_r == ovn_pkg::ST_IDLE)
    else $error("seed write started a query");

endmodule

/* sim/octave_value_noise_2d_tb.sv */
// Testbench for octave_value_noise_2d: seed writes and noise queries checked against a predictor.
module octave_value_noise_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAP_LOG2     = 6;
  localparam int unsigned SIDE_MASK    = (1 << MAP_LOG2) - 1;
  localparam int unsigned OCT_MAX      = MAP_LOG2 + 1;
  localparam longint unsigned SCALE_CAP = 64'hFF_FFFF_FFFF;
  localparam int          DRAIN_CYCLES = 7 * OCT_MAX + 19 + 8;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          RANDOM_ITEMS = 700;
  localparam int          SEGMENTS     = 6;

  localparam logic OP_SEED_WRITE  = 1'b0;
  localparam logic OP_NOISE_QUERY = 1'b1;

  localparam logic [ovn_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [ovn_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  typedef struct {
    logic [ovn_pkg::NOISE_W-1:0] noise;
    logic [5:0]                  x;
    logic [5:0]                  y;
  } noise_expect_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic [ovn_pkg::IN_TDATA_W-1:0] in_tdata;
  logic                           in_tuser;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ovn_pkg::NOISE_W-1:0]    out_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ovn_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ovn_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [ovn_pkg::SEED_W-1:0] seed_map [0:4095];
  bit                         seed_known [0:4095];
  logic [ovn_pkg::OCT_W-1:0]  oct_cfg      = ovn_pkg::OCTAVE_COUNT_RST;
  logic [ovn_pkg::BIAS_W-1:0] inv_bias_cfg = ovn_pkg::INVERSE_BIAS_RST;

  noise_expect_t noise_expected [$];
  int            mismatch_count = 0;
  int            items_sent = 0;
  bit            idle_on = 1'b1;
  bit            hold_toggle = 1'b0;
  bit            hold_seen = 1'b0;
  int            hold_left = 0;

  octave_value_noise_2d #(
    .MAP_SIDE_LOG2(MAP_LOG2)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6ns clk = 1'b1;
    #6ns clk = 1'b0;
  end

  function automatic int unsigned octaves_in_use();
    int unsigned n;
    n = oct_cfg;
    if (n == 0) n = 1;
    if (n > OCT_MAX) n = OCT_MAX;
    return n;
  endfunction

  function automatic logic [ovn_pkg::NOISE_W-1:0] predict_noise(input logic [5:0] px,
                                                                input logic [5:0] py);
    longint unsigned scale, wsum, acc, bx, by, top, bot, v, w;
    int unsigned n, o, pl, pm, x, y, x1, y1, x2, y2;
    x = px;
    y = py;
    scale = 65536;
    wsum = 0;
    acc = 0;
    n = octaves_in_use();
    for (o = 0; o < n; o++) begin
      pl = MAP_LOG2 - o;
      pm = (1 << pl) - 1;
      x1 = x & ~pm & SIDE_MASK;
      y1 = y & ~pm & SIDE_MASK;
      x2 = (x1 + (1 << pl)) & SIDE_MASK;
      y2 = (y1 + (1 << pl)) & SIDE_MASK;
      bx = x & pm;
      bx = bx << (16 - pl);
      by = y & pm;
      by = by << (16 - pl);
      top = (65536 - bx) * seed_map[(y1 << MAP_LOG2) | x1]
          + bx * seed_map[(y1 << MAP_LOG2) | x2];
      bot = (65536 - bx) * seed_map[(y2 << MAP_LOG2) | x1]
          + bx * seed_map[(y2 << MAP_LOG2) | x2];
      v = (65536 - by) * top + by * bot;
      w = (v + 64'h8000_0000) >> 32;
      acc += w * scale;
      wsum += scale;
      if (o + 1 < n) begin
        scale = (scale * inv_bias_cfg + 2048) >> 12;
        if (scale > SCALE_CAP) scale = SCALE_CAP;
      end
    end
    w = (acc + (wsum >> 1)) / wsum;
    return w[ovn_pkg::NOISE_W-1:0];
  endfunction

  function automatic logic [ovn_pkg::SEED_W-1:0] pick_seed();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return ovn_pkg::SEED_W'($urandom);
    endcase
  endfunction

  task automatic push_item(input logic op, input logic [5:0] x, input logic [5:0] y,
                           input logic [ovn_pkg::SEED_W-1:0] seed);
    noise_expect_t e;
    if (idle_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, seed, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (op == OP_SEED_WRITE) begin
      seed_map[{y, x}]   = seed;
      seed_known[{y, x}] = 1'b1;
    end else begin
      e.noise = predict_noise(x, y);
      e.x = x;
      e.y = y;
      noise_expected.push_back(e);
    end
  endtask

  // write every corner the query will read that has no seed yet
  task automatic fill_corners(input logic [5:0] x, input logic [5:0] y);
    int unsigned n, o, c, pl, pm, cx, cy;
    n = octaves_in_use();
    for (o = 0; o < n; o++) begin
      pl = MAP_LOG2 - o;
      pm = (1 << pl) - 1;
      for (c = 0; c < 4; c++) begin
        cx = x & ~pm & SIDE_MASK;
        cy = y & ~pm & SIDE_MASK;
        if (c[0]) cx = (cx + (1 << pl)) & SIDE_MASK;
        if (c[1]) cy = (cy + (1 << pl)) & SIDE_MASK;
        if (!seed_known[(cy << MAP_LOG2) | cx])
          push_item(OP_SEED_WRITE, cx[5:0], cy[5:0], pick_seed());
      end
    end
  endtask

  task automatic query_cell(input logic [5:0] x, input logic [5:0] y);
    fill_corners(x, y);
    push_item(OP_NOISE_QUERY, x, y, ovn_pkg::SEED_W'($urandom));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ovn_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ovn_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ovn_pkg::CFG_OCTAVE_COUNT) oct_cfg = data[ovn_pkg::OCT_W-1:0];
    else if (idx == ovn_pkg::CFG_INVERSE_BIAS) inv_bias_cfg = data;
  endtask

  task automatic set_config(input logic [ovn_pkg::CFG_DATA_W-1:0] octaves,
                            input logic [ovn_pkg::CFG_DATA_W-1:0] bias);
    settle();
    cfg_write(ovn_pkg::CFG_OCTAVE_COUNT, octaves);
    cfg_write(ovn_pkg::CFG_INVERSE_BIAS, bias);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_config();
    query_cell(6'd0, 6'd0);
    query_cell(6'd63, 6'd63);
    query_cell(6'd37, 6'd21);
  endtask

  task automatic test_octave_range();
    set_config(16'd1, 16'd4096);
    query_cell(6'd63, 6'd0);
    set_config(16'd0, 16'd2048);
    query_cell(6'd5, 6'd9);
    set_config(16'hFFFF, 16'hFFFF);
    query_cell(6'd63, 6'd63);
    set_config(16'd7, 16'd0);
    query_cell(6'd1, 6'd62);
    set_config(16'd6, 16'd1);
    query_cell(6'd33, 6'd31);
  endtask

  task automatic test_unused_index();
    settle();
    cfg_write(CFG_UNUSED_A, 16'hFFFF);
    cfg_write(CFG_UNUSED_B, 16'h0000);
    cfg_valid <= 1'b0;
    query_cell(6'd17, 6'd42);
  endtask

  task automatic test_seed_overwrite();
    fill_corners(6'd10, 6'd10);
    push_item(OP_SEED_WRITE, 6'd10, 6'd10, 16'h0000);
    push_item(OP_SEED_WRITE, 6'd10, 6'd10, 16'hFFFF);
    query_cell(6'd10, 6'd10);
  endtask

  task automatic test_output_hold();
    int k;
    set_config(16'd7, 16'd3000);
    for (k = 0; k < 6; k++) fill_corners(6'(20 + k), 6'd40);
    hold_toggle <= ~hold_toggle;
    for (k = 0; k < 6; k++) begin
      push_item(OP_NOISE_QUERY, 6'(20 + k), 6'd40, ovn_pkg::SEED_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int seg, start, target;
    logic [2:0] oct;
    logic [ovn_pkg::CFG_DATA_W-1:0] bias;
    logic [5:0] hx, hy, x, y;
    start = items_sent;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      oct = (seg == 0) ? 3'd7 : (seg == 1) ? 3'd1 : 3'($urandom_range(7));
      case ($urandom_range(4))
        0: bias = 16'd0;
        1: bias = 16'd1;
        2: bias = 16'hFFFF;
        3: bias = 16'd4096;
        default: bias = ovn_pkg::CFG_DATA_W'($urandom);
      endcase
      set_config((ovn_pkg::CFG_DATA_W'($urandom) & 16'hFFF8) | oct, bias);
      idle_on <= (seg != 2);
      hx = 6'($urandom);
      hy = 6'($urandom);
      target = start + (seg + 1) * RANDOM_ITEMS / SEGMENTS;
      while (items_sent < target) begin
        if ($urandom_range(99) < 40) begin
          push_item(OP_SEED_WRITE, 6'($urandom), 6'($urandom), pick_seed());
        end else begin
          if ($urandom_range(1)) begin
            x = hx + 6'($urandom_range(15));
            y = hy + 6'($urandom_range(15));
          end else begin
            x = 6'($urandom);
            y = 6'($urandom);
          end
          query_cell(x, y);
        end
      end
    end
    idle_on <= 1'b1;
  endtask

  always @(posedge clk) begin
    hold_seen <= hold_toggle;
    if (hold_toggle != hold_seen) begin
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(99) < 30) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_noise
    noise_expect_t head;
    if (rst_n && out_tvalid && out_tready) begin
      if (noise_expected.size() == 0) begin
        mismatch_count++;
        $display("%0t: noise result %h with no query pending", $time, out_tdata);
      end else begin
        head = noise_expected.pop_front();
        if (out_tdata !== head.noise) begin
          mismatch_count++;
          $display("%0t: noise at (%0d,%0d): expected %h, actual %h",
                   $time, head.x, head.y, head.noise, out_tdata);
        end
      end
    end
  end

  initial begin
    #18ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= OP_SEED_WRITE;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= ovn_pkg::CFG_OCTAVE_COUNT;
    cfg_data   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_octave_range();
    test_unused_index();
    test_seed_overwrite();
    test_output_hold();
    test_random_traffic();
    settle();
    if (mismatch_count == 0 && noise_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
